// ----- rtl/region_range_translation_table_assert.svh -----
// Assertion macros for the region range translation table.
// Used by the port checker; needs nothing else.
`ifndef REGION_RANGE_TRANSLATION_TABLE_ASSERT_SVH
`define REGION_RANGE_TRANSLATION_TABLE_ASSERT_SVH

// same-cycle implication
`define RRTT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrtt check failed");

// next-cycle implication
`define RRTT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrtt check failed");

`endif

// ----- rtl/rrtt_pkg.sv -----
// Shared types and constants of the region range translation table.
// No dependencies.
`default_nettype none

package rrtt_pkg;

    localparam int ENTRIES    = 16;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_BITS  = 32;

    localparam int FIELD_W    = 32;
    localparam int ADDR_W     = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
    localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAGE_W     = 20;
    localparam int SLOT_OUT_W = 4;
    localparam int OP_W       = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_G2L    = 3'd2,
        OP_L2G    = 3'd3,
        OP_REG_G  = 3'd4,
        OP_REG_L  = 3'd5,
        OP_PAGE   = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_FOUND  = 3'd1,
        STAT_EXISTS     = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_PAGE_RANGE = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } ctrl_state_t;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [FIELD_W-1:0] region_key;
        logic [FIELD_W-1:0] query_address;
        logic [FIELD_W-1:0] new_global_base;
        logic [FIELD_W-1:0] new_local_base;
        logic [FIELD_W-1:0] new_length;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [FIELD_W-1:0]    translated_address;
        logic [FIELD_W-1:0]    found_region;
        logic [PAGE_W-1:0]     page_number;
        logic [SLOT_OUT_W-1:0] slot_index;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] key;
        logic [ADDR_W-1:0]  qa;
        logic               hit;
        status_t            status;
        logic [FIELD_W-1:0] xlat;
        logic [FIELD_W-1:0] region;
        logic [PAGE_W-1:0]  page;
        logic [SLOT_W-1:0]  slot;
        logic               free_hit;
        logic [SLOT_W-1:0]  free_slot;
    } tok_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] region;
        logic [ADDR_W-1:0]  gbase;
        logic [ADDR_W-1:0]  lbase;
        logic [FIELD_W-1:0] len;
    } wr_t;

endpackage

`default_nettype wire

// ----- rtl/region_range_translation_table.sv -----
// A command passes the head register, each cell register in turn and the done register.
// Busy stays high while the token walks the chain; a new command is accepted only when busy is low.
// The lookup token steps through the slot cells one cell per cycle.
// Results show on done for one cycle; the receiver cannot stall.
// Reset empties the table and drops any command in flight.
// Top level of the region range translation table; uses rrtt_pkg, rrtt_cell, rrtt_ctrl.
`default_nettype none

module region_range_translation_table
    import rrtt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output logic      done,
    output rsp_t      response
);

    tok_t chain [ENTRIES+1];
    wr_t  wr;

    rrtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .tok_head (chain[0]),
        .tok_tail (chain[ENTRIES]),
        .wr       (wr),
        .done     (done),
        .response (response)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rrtt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (SLOT_W'(i)),
            .tok_in  (chain[i]),
            .wr      (wr),
            .tok_out (chain[i+1])
        );
    end

endmodule

`default_nettype wire

// ----- rtl/rrtt_cell.sv -----
// One table slot of the translation chain: holds a region and updates the
// passing lookup token. Depends on rrtt_pkg.
`default_nettype none

module rrtt_cell
    import rrtt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] index,
    input  wire tok_t              tok_in,
    input  wire wr_t               wr,
    output tok_t                   tok_out
);

    logic               valid_reg;
    logic [FIELD_W-1:0] region_reg;
    logic [ADDR_W-1:0]  gbase_reg;
    logic [ADDR_W-1:0]  lbase_reg;
    logic [FIELD_W-1:0] len_reg;
    tok_t               tok_reg;
    tok_t               tok_next;

    logic               local_sel;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  other;
    logic [ADDR_W-1:0]  off;
    logic [ADDR_W-1:0]  xlat_sum;
    logic               ge;
    logic               in_range;
    logic               id_hit;
    logic [FIELD_W-1:0] pg;
    logic [FIELD_W-1:0] pg_lim;
    logic               clr_valid;
    logic               wr_hit;

    assign local_sel = (tok_in.op == OP_L2G) || (tok_in.op == OP_REG_L) ||
                       (tok_in.op == OP_PAGE);
    assign base      = local_sel ? lbase_reg : gbase_reg;
    assign other     = local_sel ? gbase_reg : lbase_reg;
    assign off       = tok_in.qa - base;
    assign ge        = tok_in.qa >= base;
    assign in_range  = valid_reg && ge && (FIELD_W'(off) < len_reg);
    assign xlat_sum  = off + other;
    assign id_hit    = valid_reg && (region_reg == tok_in.key);
    assign pg        = FIELD_W'(off >> PAGE_SHIFT);
    assign pg_lim    = len_reg >> PAGE_SHIFT;
    assign wr_hit    = wr.en && (wr.slot == index);

    always_comb
    begin
        tok_next  = tok_in;
        clr_valid = 1'b0;
        if (tok_in.valid && !tok_in.hit)
        begin
            case (opcode_t'(tok_in.op))
                OP_INSERT:
                begin
                    if (id_hit)
                    begin
                        tok_next.hit    = 1'b1;
                        tok_next.status = STAT_EXISTS;
                        tok_next.slot   = index;
                    end
                    else if (!valid_reg && !tok_in.free_hit)
                    begin
                        tok_next.free_hit  = 1'b1;
                        tok_next.free_slot = index;
                    end
                end
                OP_REMOVE:
                begin
                    if (id_hit)
                    begin
                        tok_next.hit    = 1'b1;
                        tok_next.status = STAT_OK;
                        tok_next.slot   = index;
                        clr_valid       = 1'b1;
                    end
                end
                OP_G2L, OP_L2G:
                begin
                    if (in_range)
                    begin
                        tok_next.hit    = 1'b1;
                        tok_next.status = STAT_OK;
                        tok_next.slot   = index;
                        tok_next.xlat   = FIELD_W'(xlat_sum);
                    end
                end
                OP_REG_G, OP_REG_L:
                begin
                    if (in_range)
                    begin
                        tok_next.hit    = 1'b1;
                        tok_next.status = STAT_OK;
                        tok_next.slot   = index;
                        tok_next.region = region_reg;
                    end
                end
                OP_PAGE:
                begin
                    if (id_hit)
                    begin
                        tok_next.hit  = 1'b1;
                        tok_next.slot = index;
                        if (!ge || (pg >= pg_lim))
                        begin
                            tok_next.status = STAT_PAGE_RANGE;
                        end
                        else
                        begin
                            tok_next.status = STAT_OK;
                            tok_next.page   = pg[PAGE_W-1:0];
                        end
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_hit)
            begin
                valid_reg <= 1'b1;
            end
            else if (clr_valid)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            region_reg <= wr.region;
            gbase_reg  <= wr.gbase;
            lbase_reg  <= wr.lbase;
            len_reg    <= wr.len;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ----- rtl/rrtt_ctrl.sv -----
// Command controller: takes a request beat, launches the token into the
// cell chain, finishes inserts and drives the result beat. Uses rrtt_pkg.
`default_nettype none

module rrtt_ctrl
    import rrtt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t request,
    output tok_t      tok_head,
    input  wire tok_t tok_tail,
    output wr_t       wr,
    output logic      done,
    output rsp_t      response
);

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;
    tok_t               head_reg;
    tok_t               head_next;
    logic [ADDR_W-1:0]  gbase_reg;
    logic [ADDR_W-1:0]  lbase_reg;
    logic [FIELD_W-1:0] len_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               done_reg;
    logic               accept;
    logic               ins_open;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tok_tail.valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_WALK:  busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    assign accept = start && !busy;

    always_comb
    begin
        head_next           = head_reg;
        head_next.valid     = 1'b0;
        if (accept)
        begin
            head_next.valid     = 1'b1;
            head_next.op        = request.opcode;
            head_next.key       = request.region_key;
            head_next.qa        = request.query_address[ADDR_W-1:0];
            head_next.hit       = 1'b0;
            head_next.status    = STAT_NOT_FOUND;
            head_next.xlat      = '0;
            head_next.region    = '0;
            head_next.page      = '0;
            head_next.slot      = '0;
            head_next.free_hit  = 1'b0;
            head_next.free_slot = '0;
        end
    end

    assign ins_open = (tok_tail.op == OP_INSERT) && !tok_tail.hit;

    always_comb
    begin
        rsp_next.status             = tok_tail.status;
        rsp_next.translated_address = tok_tail.xlat;
        rsp_next.found_region       = tok_tail.region;
        rsp_next.page_number        = tok_tail.page;
        rsp_next.slot_index         = SLOT_OUT_W'(tok_tail.slot);
        if (ins_open)
        begin
            if (tok_tail.free_hit)
            begin
                rsp_next.status     = STAT_OK;
                rsp_next.slot_index = SLOT_OUT_W'(tok_tail.free_slot);
            end
            else
            begin
                rsp_next.status     = STAT_FULL;
                rsp_next.slot_index = '0;
            end
        end
    end

    assign wr.en     = tok_tail.valid && ins_open && tok_tail.free_hit;
    assign wr.slot   = tok_tail.free_slot;
    assign wr.region = tok_tail.key;
    assign wr.gbase  = gbase_reg;
    assign wr.lbase  = lbase_reg;
    assign wr.len    = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= tok_tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gbase_reg <= request.new_global_base[ADDR_W-1:0];
            lbase_reg <= request.new_local_base[ADDR_W-1:0];
            len_reg   <= request.new_length;
        end
        if (tok_tail.valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign tok_head = head_reg;
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/rrtt_checker.sv -----
// Port checker for the region range translation table and its bind.
// Uses region_range_translation_table_assert.svh.
`default_nettype none

`include "region_range_translation_table_assert.svh"

module rrtt_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    `RRTT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `RRTT_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `RRTT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `RRTT_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done)

endmodule

bind region_range_translation_table rrtt_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
